### rtl/dcis_pkg.sv
package dcis_pkg;

   // Field widths of the channels.
   localparam int TEMP_W    = 16;
   localparam int PREC_W    = 16;
   localparam int DAY_W     = 9;
   localparam int MONTH_W   = 4;
   localparam int DEGREE_W  = 24;
   localparam int COEF_W    = 16;
   localparam int CSR_IDX_W = 1;

   localparam int NUM_MONTHS = 12;

   // Month mid-points are held in half-day units, the largest being next January's.
   localparam int MID_W = 10;
   // Half-day distance from the previous December's mid-point to day zero.
   localparam logic [MID_W:0] DEC_MID_OFFSET = 11'd30;
   // Distances t0, t1 and their sum t01 never exceed 62 half-days.
   localparam int T_W = 6;

   // Reciprocal divider: quotient estimate is (num * floor(2^22 / den)) >> 22.
   localparam int DIV_NUM_W   = 21;
   localparam int RECIP_W     = 18;
   localparam int RECIP_SHIFT = 22;
   localparam int QUO_W       = DIV_NUM_W + RECIP_W - RECIP_SHIFT;
   localparam int DEN_W       = 6;

   localparam logic [DAY_W-1:0] DAYS_PER_YEAR = 9'd365;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_SMOOTH_COEF = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RESET_DAY   = 1'd1;

   localparam logic [COEF_W-1:0] SMOOTH_COEF_RESET = 16'd61309;
   localparam logic [DAY_W-1:0]  RESET_DAY_RESET   = 9'd1;

   // Item kinds.
   localparam logic KIND_LOAD = 1'b0;
   localparam logic KIND_DAY  = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic [MONTH_W-1:0]        month;
      logic signed [TEMP_W-1:0]  month_temp;
      logic [PREC_W-1:0]         month_prec;
      logic [DAY_W-1:0]          day;
      logic                      add_delta;
      logic signed [TEMP_W-1:0]  temp_delta;
      logic signed [PREC_W-1:0]  prec_delta;
   } req_payload_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0]  daily_temp;
      logic [PREC_W-1:0]         daily_prec;
      logic signed [TEMP_W-1:0]  smoothed_temp;
      logic [PREC_W-1:0]         smoothed_prec;
      logic [DEGREE_W-1:0]       degree_days;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0] index;
      logic [COEF_W-1:0]    data;
   } csr_payload_type;

   typedef struct packed {
      logic                 start;
      logic [DIV_NUM_W-1:0] num;
      logic [DEN_W-1:0]     den;
   } div_req_type;

   // Non-leap month lengths in days.
   function automatic logic [4:0] month_len(input logic [MONTH_W-1:0] m);
      logic [4:0] len;
      case (m)
         4'd1:                        len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:     len = 5'd30;
         4'd0, 4'd2, 4'd4, 4'd6,
         4'd7, 4'd9, 4'd11:           len = 5'd31;
         default:                     len = 5'd31;
      endcase
      return len;
   endfunction

   // Mid-point of month k in half-days from day zero; k of twelve is next January.
   function automatic logic [MID_W-1:0] month_mid(input logic [MONTH_W-1:0] k);
      logic [MID_W-1:0] mid;
      case (k)
         4'd0:    mid = 10'd32;
         4'd1:    mid = 10'd91;
         4'd2:    mid = 10'd150;
         4'd3:    mid = 10'd211;
         4'd4:    mid = 10'd272;
         4'd5:    mid = 10'd333;
         4'd6:    mid = 10'd394;
         4'd7:    mid = 10'd456;
         4'd8:    mid = 10'd517;
         4'd9:    mid = 10'd578;
         4'd10:   mid = 10'd639;
         4'd11:   mid = 10'd700;
         4'd12:   mid = 10'd762;
         default: mid = 10'd762;
      endcase
      return mid;
   endfunction

   // floor(2^22 / d) for every divisor the datapath uses.
   function automatic logic [RECIP_W-1:0] recip_of(input logic [DEN_W-1:0] d);
      logic [RECIP_W-1:0] r;
      case (d)
         6'd28:   r = 18'd149796;
         6'd30:   r = 18'd139810;
         6'd31:   r = 18'd135300;
         6'd59:   r = 18'd71089;
         6'd61:   r = 18'd68759;
         6'd62:   r = 18'd67650;
         default: r = 18'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/dcis_stream_if.sv
interface dcis_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/dcis_recip_div.sv
// Two-stage divider by a small set of constant divisors: a reciprocal
// multiplication gives a quotient that is exact or one low, and a
// back-multiplication with one compare corrects it. A new division may
// start in every cycle; its product is registered, then its quotient.
module dcis_recip_div
   import dcis_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  div_req_type       div_req,
   output logic [QUO_W-1:0]  quo,
   output logic              done
);

   localparam int BACK_W = QUO_W + DEN_W;

   logic [DIV_NUM_W+RECIP_W-1:0] prod_ff;
   logic [DIV_NUM_W-1:0]         num_ff;
   logic [DEN_W-1:0]             den_ff;
   logic                         stage1_ff;
   logic                         done_ff;
   logic [QUO_W-1:0]             quo_ff;
   logic [QUO_W-1:0]             q_est;
   logic [BACK_W-1:0]            back_prod;
   logic [BACK_W-1:0]            rem;

   always_ff @(posedge clock) begin
      if (reset) begin
         stage1_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         stage1_ff <= div_req.start;
         done_ff   <= stage1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (div_req.start) begin
         prod_ff <= div_req.num * recip_of(div_req.den);
         num_ff  <= div_req.num;
         den_ff  <= div_req.den;
      end
   end

   assign q_est     = prod_ff[RECIP_SHIFT +: QUO_W];
   assign back_prod = q_est * den_ff;
   assign rem       = BACK_W'(num_ff) - back_prod;

   always_ff @(posedge clock) begin
      if (stage1_ff) begin
         quo_ff <= (rem >= BACK_W'(den_ff)) ? q_est + 1'b1 : q_est;
      end
   end

   assign quo  = quo_ff;
   assign done = done_ff;

endmodule

### rtl/daily_climate_interpolate_smooth.sv
// Daily climate interpolator. A load transfer (kind 0) writes one month's mean
// temperature (Q8.8 degrees Celsius) and precipitation total (1/16 mm) into a
// twelve-entry table and returns a result with zero daily fields and the current
// smoothed values and degree-day sum. A day transfer (kind 1) finds the two
// months whose mid-days bracket the day, interpolates temperature and daily
// precipitation linearly with truncating divisions, optionally adds the grid
// deltas with saturation, and updates the exponentially smoothed values and the
// degree-day sum, which is cleared on the configured reset day. Days above 365
// wrap into the following year. The table has no reset: every month must be
// loaded before the first day transfer, otherwise the fields derived from an
// unloaded month are meaningless. Input is taken only in IDLE; a day transfer
// steps through every sequencer state, a load transfer only through DONE. The
// sequencer reads both months from the table through its one read port one after
// the other and passes four divisions through the reciprocal divider in turn. A
// finished result sits in an output register, so a new input is taken while it
// still waits for the consumer. Configuration writes are accepted in every cycle
// and should only be made while the block is idle.
module daily_climate_interpolate_smooth
   import dcis_pkg::*;
#(
   parameter int COEF_BITS = 16
) (
   input logic           clock,
   input logic           reset,
   dcis_stream_if.sink   req_bus,
   dcis_stream_if.source rsp_bus,
   dcis_stream_if.sink   csr_bus
);

   localparam int SM_PROD_W = COEF_BITS + 17;
   localparam int SM_SUM_W  = COEF_BITS + 18;
   localparam logic [SM_SUM_W-1:0] ROUND_HALF = SM_SUM_W'(1) << (COEF_BITS - 1);
   localparam logic [TEMP_W-1:0]   SIGN_FLIP  = 16'h8000;

   // One state per step of a day transfer; the table is read in SRCH and RD0,
   // and the divider is started in RD0, RD1, TDIV and PDIV.
   typedef enum logic [13:0] {
      ST_IDLE = 14'b00_0000_0000_0001,
      ST_SRCH = 14'b00_0000_0000_0010,
      ST_RD0  = 14'b00_0000_0000_0100,
      ST_RD1  = 14'b00_0000_0000_1000,
      ST_TMUL = 14'b00_0000_0001_0000,
      ST_TSUM = 14'b00_0000_0010_0000,
      ST_TDIV = 14'b00_0000_0100_0000,
      ST_PSUM = 14'b00_0000_1000_0000,
      ST_PDIV = 14'b00_0001_0000_0000,
      ST_DEGR = 14'b00_0010_0000_0000,
      ST_PFIN = 14'b00_0100_0000_0000,
      ST_SMUL = 14'b00_1000_0000_0000,
      ST_SSUM = 14'b01_0000_0000_0000,
      ST_DONE = 14'b10_0000_0000_0000
   } state_type;

   state_type state_ff, state_in;

   // Captured input item.
   logic                     req_accept;
   logic                     is_load_ff;
   logic [DAY_W-1:0]         day_ff;
   logic [DAY_W-1:0]         day_norm;
   logic [MID_W-1:0]         day2_ff;
   logic                     add_delta_ff;
   logic signed [TEMP_W-1:0] temp_delta_ff;
   logic signed [PREC_W-1:0] prec_delta_ff;

   // Month search.
   logic [MONTH_W-1:0] k_sel;
   logic [MONTH_W-1:0] m0_sel;
   logic [MONTH_W-1:0] m1_sel;
   logic [MID_W-1:0]   mid1_sel;
   logic [MID_W-1:0]   mid0_sel;
   logic [MID_W:0]     t0_wide;
   logic [MID_W:0]     t1_wide;
   logic [MONTH_W-1:0] m1_ff;
   logic [T_W-1:0]     t0_ff;
   logic [T_W-1:0]     t1_ff;
   logic [T_W-1:0]     t01_ff;
   logic [4:0]         len0_ff;
   logic [4:0]         len1_ff;

   // Month table: temperature in the upper half, precipitation in the lower.
   logic [TEMP_W+PREC_W-1:0] tbl_mem [NUM_MONTHS];
   logic [MONTH_W-1:0]       rd_addr;
   logic [TEMP_W+PREC_W-1:0] rd_data_ff;

   // Interpolation datapath.
   logic signed [TEMP_W-1:0] temp0_ff;
   logic signed [TEMP_W-1:0] temp1_ff;
   logic signed [22:0]       tprod0_ff;
   logic signed [22:0]       tprod1_ff;
   logic signed [23:0]       tnum_ff;
   logic [23:0]              tnum_abs;
   logic                     tneg_ff;
   logic [11:0]              p0_ff;
   logic [11:0]              p1_ff;
   logic [17:0]              pprod0_ff;
   logic [17:0]              pprod1_ff;
   logic [18:0]              pnum_ff;
   logic signed [17:0]       tq_s;
   logic signed [17:0]       tsum;
   logic signed [18:0]       psum;
   logic [TEMP_W-1:0]        temp_sat;
   logic [PREC_W-1:0]        prec_sat;
   logic signed [TEMP_W-1:0] temp_ff;
   logic [PREC_W-1:0]        prec_ff;

   // Divider.
   div_req_type      div_req;
   logic [QUO_W-1:0] div_quo;
   logic             div_done;

   // Smoothing and degree-day state.
   logic [COEF_W-1:0]      coef_ff;
   logic [DAY_W-1:0]       reset_day_ff;
   logic [TEMP_W-1:0]      smooth_temp_ff;
   logic [PREC_W-1:0]      smooth_prec_ff;
   logic [DEGREE_W-1:0]    degree_ff;
   logic [DEGREE_W-1:0]    deg_base;
   logic [DEGREE_W:0]      deg_add;
   logic [DEGREE_W-1:0]    deg_next;
   logic [COEF_BITS-1:0]   c_val;
   logic [COEF_BITS:0]     a_val;
   logic [15:0]            sm_x;
   logic [15:0]            sm_s;
   logic [SM_PROD_W-1:0]   sm_a_ff;
   logic [SM_PROD_W-2:0]   sm_c_ff;
   logic [SM_SUM_W-1:0]    sm_sum;
   logic [15:0]            sm_res;

   // Output register.
   logic            rsp_valid_ff;
   rsp_payload_type rsp_data_ff;
   logic            out_free;

   // ---------------------------------------------------------------------
   // Input side and configuration
   // ---------------------------------------------------------------------
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;

   // Days beyond the year fall on the same bracket as the day one year earlier.
   assign day_norm = (req_bus.payload.day > DAYS_PER_YEAR)
                   ? req_bus.payload.day - DAYS_PER_YEAR : req_bus.payload.day;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         is_load_ff    <= (req_bus.payload.kind == KIND_LOAD);
         day_ff        <= req_bus.payload.day;
         day2_ff       <= {day_norm, 1'b0};
         add_delta_ff  <= req_bus.payload.add_delta;
         temp_delta_ff <= req_bus.payload.temp_delta;
         prec_delta_ff <= req_bus.payload.prec_delta;
      end
   end

   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff      <= SMOOTH_COEF_RESET;
         reset_day_ff <= RESET_DAY_RESET;
      end else if (csr_bus.valid && csr_bus.ready) begin
         case (csr_bus.payload.index)
            CSR_SMOOTH_COEF: coef_ff      <= csr_bus.payload.data;
            CSR_RESET_DAY:   reset_day_ff <= csr_bus.payload.data[DAY_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // Month table. Writes happen only on a load transfer in IDLE and read data is
   // used only during a day transfer, so the two never meet on the same entry.
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (req_accept && req_bus.payload.kind == KIND_LOAD
          && req_bus.payload.month < MONTH_W'(NUM_MONTHS)) begin
         tbl_mem[req_bus.payload.month] <= {req_bus.payload.month_temp,
                                            req_bus.payload.month_prec};
      end
      rd_data_ff <= tbl_mem[rd_addr];
   end

   assign rd_addr = (state_ff == ST_SRCH) ? m0_sel : m1_ff;

   // ---------------------------------------------------------------------
   // Month search: the first mid-point at or after the day closes the bracket.
   // ---------------------------------------------------------------------
   always_comb begin
      k_sel = MONTH_W'(NUM_MONTHS);
      for (int i = NUM_MONTHS - 1; i >= 0; i--) begin
         if (day2_ff <= month_mid(MONTH_W'(i))) k_sel = MONTH_W'(i);
      end
   end

   assign m1_sel   = (k_sel == MONTH_W'(NUM_MONTHS)) ? '0 : k_sel;
   assign m0_sel   = (k_sel == '0) ? MONTH_W'(NUM_MONTHS - 1) : k_sel - 1'b1;
   assign mid1_sel = month_mid(k_sel);
   assign mid0_sel = month_mid(k_sel - 1'b1);
   // Before the first January mid-point the lower bound is the previous December.
   assign t0_wide  = (k_sel == '0) ? {1'b0, day2_ff} + DEC_MID_OFFSET
                                   : {1'b0, day2_ff} - {1'b0, mid0_sel};
   assign t1_wide  = {1'b0, mid1_sel} - {1'b0, day2_ff};

   always_ff @(posedge clock) begin
      if (state_ff == ST_SRCH) begin
         m1_ff   <= m1_sel;
         t0_ff   <= t0_wide[T_W-1:0];
         t1_ff   <= t1_wide[T_W-1:0];
         len0_ff <= month_len(m0_sel);
         len1_ff <= month_len(m1_sel);
         t01_ff  <= {1'b0, month_len(m0_sel)} + {1'b0, month_len(m1_sel)};
      end
   end

   // ---------------------------------------------------------------------
   // Divider requests: P0 / len0, P1 / len1, |temp numerator| / t01,
   // precipitation numerator / t01.
   // ---------------------------------------------------------------------
   assign tnum_abs = tnum_ff[23] ? 24'(-tnum_ff) : 24'(tnum_ff);

   always_comb begin
      div_req.start = 1'b0;
      div_req.num   = '0;
      div_req.den   = '0;
      case (state_ff)
         ST_RD0: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(rd_data_ff[PREC_W-1:0]);
            div_req.den   = {1'b0, len0_ff};
         end
         ST_RD1: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(rd_data_ff[PREC_W-1:0]);
            div_req.den   = {1'b0, len1_ff};
         end
         ST_TDIV: begin
            div_req.start = 1'b1;
            div_req.num   = tnum_abs[DIV_NUM_W-1:0];
            div_req.den   = t01_ff;
         end
         ST_PDIV: begin
            div_req.start = 1'b1;
            div_req.num   = DIV_NUM_W'(pnum_ff);
            div_req.den   = t01_ff;
         end
         default: ;
      endcase
   end

   dcis_recip_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .quo     (div_quo),
      .done    (div_done)
   );

   // ---------------------------------------------------------------------
   // Final temperature and precipitation with optional deltas. Saturation is
   // harmless without deltas, since the interpolated values already fit.
   // ---------------------------------------------------------------------
   always_comb begin
      tq_s = tneg_ff ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
      tsum = tq_s + (add_delta_ff ? 18'(temp_delta_ff) : 18'sd0);
      if (tsum > 18'sd32767)       temp_sat = 16'h7FFF;
      else if (tsum < -18'sd32768) temp_sat = 16'h8000;
      else                         temp_sat = tsum[TEMP_W-1:0];

      psum = $signed({2'b00, div_quo}) + (add_delta_ff ? 19'(prec_delta_ff) : 19'sd0);
      if (psum < 19'sd0)           prec_sat = '0;
      else if (psum > 19'sd65535)  prec_sat = 16'hFFFF;
      else                         prec_sat = psum[PREC_W-1:0];
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_RD0:  temp0_ff <= rd_data_ff[TEMP_W+PREC_W-1:PREC_W];
         ST_RD1:  temp1_ff <= rd_data_ff[TEMP_W+PREC_W-1:PREC_W];
         ST_TMUL: begin
            p0_ff     <= div_quo[11:0];
            tprod0_ff <= $signed({1'b0, t1_ff}) * temp0_ff;
            tprod1_ff <= $signed({1'b0, t0_ff}) * temp1_ff;
         end
         ST_TSUM: begin
            p1_ff   <= div_quo[11:0];
            tnum_ff <= 24'(tprod0_ff) + 24'(tprod1_ff);
         end
         ST_TDIV: begin
            tneg_ff   <= tnum_ff[23];
            pprod0_ff <= t1_ff * p0_ff;
            pprod1_ff <= t0_ff * p1_ff;
         end
         ST_PSUM: pnum_ff <= {1'b0, pprod0_ff} + {1'b0, pprod1_ff};
         ST_PDIV: temp_ff <= temp_sat;
         ST_PFIN: prec_ff <= prec_sat;
         default: ;
      endcase
   end

   // ---------------------------------------------------------------------
   // Degree-day sum: cleared first on the reset day, then a positive
   // temperature is added with saturation.
   // ---------------------------------------------------------------------
   assign deg_base = (day_ff == reset_day_ff) ? '0 : degree_ff;
   assign deg_add  = {1'b0, deg_base} + DEGREE_W'(temp_ff[TEMP_W-2:0]);
   assign deg_next = (temp_ff > 16'sd0)
                   ? (deg_add[DEGREE_W] ? '1 : deg_add[DEGREE_W-1:0]) : deg_base;

   // ---------------------------------------------------------------------
   // Exponential smoothing, rounded half up. The temperature is offset to an
   // unsigned value by flipping its sign bit. One multiplier pair serves the
   // temperature in DEGR and the precipitation in SMUL.
   // ---------------------------------------------------------------------
   assign c_val  = COEF_BITS'(coef_ff);
   assign a_val  = {1'b1, {COEF_BITS{1'b0}}} - {1'b0, c_val};
   assign sm_x   = (state_ff == ST_DEGR) ? temp_ff ^ SIGN_FLIP : prec_ff;
   assign sm_s   = (state_ff == ST_DEGR) ? smooth_temp_ff ^ SIGN_FLIP : smooth_prec_ff;
   assign sm_sum = SM_SUM_W'(sm_a_ff) + SM_SUM_W'(sm_c_ff) + ROUND_HALF;
   assign sm_res = sm_sum[COEF_BITS +: 16];

   always_ff @(posedge clock) begin
      if (state_ff == ST_DEGR || state_ff == ST_SMUL) begin
         sm_a_ff <= a_val * sm_x;
         sm_c_ff <= c_val * sm_s;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         smooth_temp_ff <= '0;
         smooth_prec_ff <= '0;
         degree_ff      <= '0;
      end else begin
         if (state_ff == ST_DEGR) degree_ff      <= deg_next;
         if (state_ff == ST_PFIN) smooth_temp_ff <= sm_res ^ SIGN_FLIP;
         if (state_ff == ST_SSUM) smooth_prec_ff <= sm_res;
      end
   end

   // ---------------------------------------------------------------------
   // Sequencer
   // ---------------------------------------------------------------------
   assign out_free = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               state_in = (req_bus.payload.kind == KIND_DAY) ? ST_SRCH : ST_DONE;
            end
         end
         ST_SRCH: state_in = ST_RD0;
         ST_RD0:  state_in = ST_RD1;
         ST_RD1:  state_in = ST_TMUL;
         ST_TMUL: state_in = ST_TSUM;
         ST_TSUM: state_in = ST_TDIV;
         ST_TDIV: state_in = ST_PSUM;
         ST_PSUM: state_in = ST_PDIV;
         ST_PDIV: state_in = ST_DEGR;
         ST_DEGR: state_in = ST_PFIN;
         ST_PFIN: state_in = ST_SMUL;
         ST_SMUL: state_in = ST_SSUM;
         ST_SSUM: state_in = ST_DONE;
         ST_DONE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else       state_ff <= state_in;
   end

   // ---------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == ST_DONE && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff.daily_temp    <= is_load_ff ? '0 : temp_ff;
         rsp_data_ff.daily_prec    <= is_load_ff ? '0 : prec_ff;
         rsp_data_ff.smoothed_temp <= smooth_temp_ff;
         rsp_data_ff.smoothed_prec <= smooth_prec_ff;
         rsp_data_ff.degree_days   <= degree_ff;
      end
   end

   assign rsp_bus.valid   = rsp_valid_ff;
   assign rsp_bus.payload = rsp_data_ff;

   // ---------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------
   // Every state that consumes a quotient must find the divider finished.
   a_div_timing: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_TMUL || state_ff == ST_TSUM || state_ff == ST_PDIV
       || state_ff == ST_PFIN) |-> div_done)
      else $error("divider quotient not ready when consumed");

   // The two half-day distances must add up to the span of the bracket.
   a_bracket: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_RD0) |-> (({1'b0, t0_ff} + {1'b0, t1_ff}) == {1'b0, t01_ff}))
      else $error("month bracket distances inconsistent");

   // Away from the reset day the degree-day sum never falls.
   a_degree_mono: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEGR && day_ff != reset_day_ff) |=> (degree_ff >= $past(degree_ff)))
      else $error("degree-day sum decreased");

   // A result appears only after the sequencer has finished an item.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result raised outside the completion step");

endmodule

### verif/dcis_climate_checker.sv
`timescale 1ns / 100ps

// Watches the request, response and register channels, keeps its own copy of
// the climate state and compares every response transfer with the oldest
// prediction.
module dcis_climate_checker
   import dcis_pkg::*;
#(
   parameter int COEF_BITS = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   input  logic            req_ready,
   input  req_payload_type req_payload,
   input  logic            rsp_valid,
   input  logic            rsp_ready,
   input  rsp_payload_type rsp_payload,
   input  logic            csr_valid,
   input  logic            csr_ready,
   input  csr_payload_type csr_payload,
   output int              pending,
   output int              mismatches
);

   localparam int MAX_REPORTS = 60;

   logic signed [TEMP_W-1:0] month_temp_tab [NUM_MONTHS];
   logic [PREC_W-1:0]        month_prec_tab [NUM_MONTHS];
   logic signed [TEMP_W-1:0] smooth_temp_q;
   logic [PREC_W-1:0]        smooth_prec_q;
   int                       degree_total;
   logic [COEF_W-1:0]        smooth_coef;
   logic [DAY_W-1:0]         clear_day;

   rsp_payload_type predicted_days [$];

   initial mismatches = 0;

   function automatic int month_days(input int m);
      case (m)
         1:              return 28;
         3, 5, 8, 10:    return 30;
         default:        return 31;
      endcase
   endfunction

   // Weighted mean of a fresh sample and the held value, rounded half up.
   function automatic longint unsigned blend(input longint unsigned fresh,
                                             input longint unsigned held);
      longint unsigned keep;
      longint unsigned take;
      keep = smooth_coef;
      keep = keep & ((64'd1 << COEF_BITS) - 1);
      take = (64'd1 << COEF_BITS) - keep;
      return (take * fresh + keep * held + (64'd1 << (COEF_BITS - 1))) >> COEF_BITS;
   endfunction

   function automatic rsp_payload_type advance_climate(input req_payload_type item);
      rsp_payload_type  res;
      int               dbl, m_lo, m_hi, first_day, mid_lo, mid_hi;
      int               t_lo, t_hi, span, temp, prec, p_lo, p_hi;
      longint unsigned  r;
      res = '0;
      if (item.kind == KIND_LOAD) begin
         if (item.month < NUM_MONTHS) begin
            month_temp_tab[item.month] = item.month_temp;
            month_prec_tab[item.month] = item.month_prec;
         end
      end else begin
         // Walk month by month until the later mid-point is not before the day;
         // the walk wraps round the year for days beyond the last one.
         dbl       = 2 * int'(item.day);
         m_lo      = NUM_MONTHS - 1;
         m_hi      = 0;
         first_day = 1;
         mid_lo    = -30;
         mid_hi    = 32;
         while (dbl > mid_hi) begin
            m_lo      = (m_lo + 1) % NUM_MONTHS;
            m_hi      = (m_hi + 1) % NUM_MONTHS;
            first_day = first_day + month_days(m_lo);
            mid_lo    = 2 * first_day - (month_days(m_lo) + 1);
            mid_hi    = 2 * first_day + (month_days(m_hi) - 1);
         end
         span = mid_hi - mid_lo;
         t_lo = dbl - mid_lo;
         t_hi = mid_hi - dbl;

         temp = (t_hi * int'(month_temp_tab[m_lo]) + t_lo * int'(month_temp_tab[m_hi])) / span;
         p_lo = int'(month_prec_tab[m_lo]) / month_days(m_lo);
         p_hi = int'(month_prec_tab[m_hi]) / month_days(m_hi);
         prec = (t_hi * p_lo + t_lo * p_hi) / span;

         if (item.add_delta) begin
            temp = temp + int'($signed(item.temp_delta));
            if (temp > 32767) temp = 32767;
            if (temp < -32768) temp = -32768;
            prec = prec + int'($signed(item.prec_delta));
            if (prec < 0) prec = 0;
            if (prec > 65535) prec = 65535;
         end

         if (item.day == clear_day) degree_total = 0;
         if (temp > 0) begin
            degree_total = degree_total + temp;
            if (degree_total > 24'hFFFFFF) degree_total = 24'hFFFFFF;
         end

         // Temperatures are smoothed with an offset that keeps them non-negative.
         r = blend(longint'(temp + 32768), longint'(int'(smooth_temp_q) + 32768));
         smooth_temp_q = TEMP_W'(r - 32768);
         r = blend(longint'(prec), longint'(smooth_prec_q));
         smooth_prec_q = PREC_W'(r);

         res.daily_temp = TEMP_W'(temp);
         res.daily_prec = PREC_W'(prec);
      end
      res.smoothed_temp = smooth_temp_q;
      res.smoothed_prec = smooth_prec_q;
      res.degree_days   = DEGREE_W'(degree_total);
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [DEGREE_W-1:0] want,
                                input logic [DEGREE_W-1:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= MAX_REPORTS)
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, field, want, got);
      end
   endtask

   always @(posedge clock) begin
      rsp_payload_type want;
      if (reset) begin
         foreach (month_temp_tab[m]) begin
            month_temp_tab[m] = '0;
            month_prec_tab[m] = '0;
         end
         smooth_temp_q = '0;
         smooth_prec_q = '0;
         degree_total  = 0;
         smooth_coef   = SMOOTH_COEF_RESET;
         clear_day     = RESET_DAY_RESET;
         predicted_days.delete();
         pending <= 0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_payload.index == CSR_SMOOTH_COEF)
               smooth_coef = csr_payload.data;
            else if (csr_payload.index == CSR_RESET_DAY)
               clear_day = csr_payload.data[DAY_W-1:0];
         end
         // Responses are matched before new requests are added, so a response
         // can never be paired with the request taken in the same cycle.
         if (rsp_valid && rsp_ready) begin
            if (predicted_days.size() == 0) begin
               mismatches++;
               $display("%0t: response with nothing expected, actual 0x%0h",
                        $time, rsp_payload);
            end else begin
               want = predicted_days.pop_front();
               compare_field("daily_temp", want.daily_temp, rsp_payload.daily_temp);
               compare_field("daily_prec", want.daily_prec, rsp_payload.daily_prec);
               compare_field("smoothed_temp", want.smoothed_temp, rsp_payload.smoothed_temp);
               compare_field("smoothed_prec", want.smoothed_prec, rsp_payload.smoothed_prec);
               compare_field("degree_days", want.degree_days, rsp_payload.degree_days);
            end
         end
         if (req_valid && req_ready)
            predicted_days.push_back(advance_climate(req_payload));
         pending <= predicted_days.size();
      end
   end

endmodule

### verif/tb_daily_climate_interpolate_smooth.sv
`timescale 1ns / 100ps

// Top of the climate interpolator testbench. It generates the clock and reset,
// drives the request and register channels, toggles the response ready line and
// gives the verdict. All prediction and comparison is left to the checker.
module tb_daily_climate_interpolate_smooth;
   import dcis_pkg::*;

   // Limit for the watchdog, with a wide margin over the slowest legal run.
   localparam int CYCLE_LIMIT    = 1_000_000;
   // Settling wait before any register write and before the verdict; it is longer
   // than a day transfer takes inside the block.
   localparam int SETTLE_CYCLES  = 32;
   // Length of the deliberate response hold-off.
   localparam int HOLD_OFF_CYCLES = 400;

   logic clock = 1'b0;
   logic reset;
   int   pending;
   int   mismatches;
   int   cycles;
   int   calm_left;
   bit   hold_rsp;
   int   rd_third;

   dcis_stream_if #(.payload_type(req_payload_type)) req_if ();
   dcis_stream_if #(.payload_type(rsp_payload_type)) rsp_if ();
   dcis_stream_if #(.payload_type(csr_payload_type)) csr_if ();

   daily_climate_interpolate_smooth dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if),
      .csr_bus (csr_if)
   );

   dcis_climate_checker checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_ready   (req_if.ready),
      .req_payload (req_if.payload),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .rsp_payload (rsp_if.payload),
      .csr_valid   (csr_if.valid),
      .csr_ready   (csr_if.ready),
      .csr_payload (csr_if.payload),
      .pending     (pending),
      .mismatches  (mismatches)
   );

   always #4 clock = ~clock;

   // Idle lengths shared by both sides: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // A load transfer; the day and delta fields are ignored by the block, so they
   // carry random values.
   function automatic req_payload_type load_item(input int m, input int t, input int p);
      req_payload_type it;
      it.kind       = KIND_LOAD;
      it.month      = MONTH_W'(m);
      it.month_temp = TEMP_W'(t);
      it.month_prec = PREC_W'(p);
      it.day        = DAY_W'($urandom);
      it.add_delta  = 1'($urandom);
      it.temp_delta = TEMP_W'($urandom);
      it.prec_delta = PREC_W'($urandom);
      return it;
   endfunction

   // A day transfer; the month fields are ignored and carry random values.
   function automatic req_payload_type day_item(input int d, input bit add,
                                                input int td, input int pd);
      req_payload_type it;
      it.kind       = KIND_DAY;
      it.month      = MONTH_W'($urandom);
      it.month_temp = TEMP_W'($urandom);
      it.month_prec = PREC_W'($urandom);
      it.day        = DAY_W'(d);
      it.add_delta  = add;
      it.temp_delta = TEMP_W'(td);
      it.prec_delta = PREC_W'(pd);
      return it;
   endfunction

   // Random transfer. In the warm mode the tables are filled with high temperatures
   // and large positive deltas are added while the clearing day is avoided, so that
   // the degree-day sum climbs all the way to saturation.
   function automatic req_payload_type random_item(input int load_pct, input bit warm,
                                                   input int rd);
      int m, t, p, d, r;
      bit add;
      int td, pd;
      m = ($urandom_range(0, 19) == 0) ? $urandom_range(12, 15) : $urandom_range(0, 11);
      if (warm)
         t = $urandom_range(12800, 32767);
      else if ($urandom_range(0, 1))
         t = $urandom;
      else
         t = int'($urandom_range(0, 11520)) - 2560;
      p = $urandom_range(0, 1) ? $urandom : $urandom_range(0, 4000);
      if ($urandom_range(0, 99) < load_pct)
         return load_item(m, t, p);

      r = $urandom_range(0, 99);
      if (warm) begin
         do d = $urandom_range(1, 511); while (d == rd);
      end else if (r < 8)
         d = rd;
      else if (r < 12)
         d = 0;
      else if (r < 18)
         d = $urandom_range(366, 511);
      else
         d = $urandom_range(1, 365);

      if (warm) begin
         add = ($urandom_range(0, 9) != 0);
         td  = $urandom_range(8000, 32767);
      end else begin
         add = $urandom_range(0, 1);
         td  = $urandom_range(0, 1) ? $urandom : int'($urandom_range(0, 1024)) - 512;
      end
      pd = ($urandom_range(0, 9) < 3) ? $urandom : int'($urandom_range(0, 512)) - 256;
      return day_item(d, add, td, pd);
   endfunction

   // Offer one request and wait for its transfer. Unless a gap is drawn, valid is
   // left high so that a following request can go out in the very next cycle.
   task automatic offer(input req_payload_type item);
      int gap;
      req_if.payload <= item;
      req_if.valid   <= 1'b1;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      if (calm_left > 0) begin
         calm_left--;
         gap = 0;
      end else if ($urandom_range(0, 99) == 0) begin
         calm_left = $urandom_range(20, 40);
         gap = 0;
      end else begin
         gap = pick_gap();
      end
      if (gap > 0) begin
         req_if.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop sending and let every outstanding response arrive, then give the block
   // its full latency before anything else happens.
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Write both registers in back-to-back transfers; only called while idle.
   task automatic write_regs(input int coef, input int rd);
      csr_payload_type w;
      w.index = CSR_SMOOTH_COEF;
      w.data  = COEF_W'(coef);
      csr_if.payload <= w;
      csr_if.valid   <= 1'b1;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      w.index = CSR_RESET_DAY;
      w.data  = COEF_W'(rd);
      csr_if.payload <= w;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Response side: runs of ready broken by stalls of random length, and one long
   // hold-off on request so that the block's output and input both back up.
   initial begin
      int run;
      int stall;
      rsp_if.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            hold_rsp = 1'b0;
            rsp_if.ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end
         rsp_if.ready <= 1'b1;
         run = ($urandom_range(0, 19) == 0) ? $urandom_range(100, 200) : $urandom_range(1, 40);
         repeat (run) @(posedge clock);
         stall = pick_gap();
         if (stall > 0) begin
            rsp_if.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   // Watchdog: a run that has not finished by the limit has hung.
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("tb_daily_climate_interpolate_smooth: FAIL");
      $finish;
   end

   initial begin
      calm_left = 0;
      hold_rsp  = 1'b0;
      reset          <= 1'b1;
      req_if.valid   <= 1'b0;
      req_if.payload <= '0;
      csr_if.valid   <= 1'b0;
      csr_if.payload <= '0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part. Every month is loaded before the first day transfer, since
      // the tables hold nothing useful until written. January and February carry
      // the temperature and precipitation extremes.
      offer(load_item(0, -32768, 65535));
      offer(load_item(1, 32767, 0));
      for (int m = 2; m < NUM_MONTHS; m++)
         offer(load_item(m, m * 700 - 3000, 800 + m * 300));
      // Month indexes above eleven must leave the tables untouched.
      offer(load_item(12, 32767, 65535));
      offer(load_item(15, -32768, 16'h1234));
      // Day zero lies between December and January.
      offer(day_item(0, 1'b0, 0, 0));
      // The default clearing day, followed by January's exact mid-point.
      offer(day_item(1, 1'b0, 0, 0));
      offer(day_item(16, 1'b1, 100, -5));
      offer(day_item(365, 1'b1, -200, 40));
      // The highest encodable day wraps well into the following year.
      offer(day_item(511, 1'b1, 16'h5A5A, 16'hA5A5));
      // Just past February's mid-point the temperature saturates upwards.
      offer(day_item(46, 1'b1, 32767, 0));
      // Between the January and February mid-points it saturates downwards and
      // the precipitation is clamped at zero.
      offer(day_item(30, 1'b1, -32768, -32768));
      offer(day_item(200, 1'b1, 0, 32767));

      // Default coefficient and clearing day.
      repeat (220) offer(random_item(20, 1'b0, RESET_DAY_RESET));

      // No smoothing at all, and clearing on the last day of the year.
      drain();
      write_regs(0, 365);
      repeat (150) offer(random_item(20, 1'b0, 365));

      // Almost all weight on the held value; part way through, the response side is held
      // off while requests keep coming without gaps.
      drain();
      rd_third = $urandom_range(2, 364);
      write_regs(65535, rd_third);
      for (int i = 0; i < 150; i++) begin
         if (i == 50) begin
            hold_rsp  = 1'b1;
            calm_left = 30;
         end
         offer(random_item(20, 1'b0, rd_third));
      end

      // Warm run towards degree-day saturation with a random coefficient.
      drain();
      write_regs($urandom_range(0, 65535), 365);
      for (int m = 0; m < NUM_MONTHS; m++)
         offer(load_item(m, $urandom_range(12800, 32767), $urandom_range(0, 65535)));
      repeat (560) offer(random_item(8, 1'b1, 365));

      // Back to the reset values, with the sum cleared again on day one.
      drain();
      write_regs(SMOOTH_COEF_RESET, RESET_DAY_RESET);
      repeat (40) offer(random_item(20, 1'b0, RESET_DAY_RESET));

      drain();
      if (mismatches == 0)
         $display("tb_daily_climate_interpolate_smooth: PASS");
      else
         $display("tb_daily_climate_interpolate_smooth: FAIL");
      $finish;
   end

endmodule
